/* sv/dlle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared constants, command codes and control/status types for the doubly
// linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

    localparam int POOL_NODES = 256;
    localparam int IDX_W      = $clog2(POOL_NODES);
    localparam int LNK_W      = IDX_W + 1;
    localparam int CMD_W      = 4;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;
    localparam int OUT_W      = 9;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_NODES);

    localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 4'd8;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_FULL,
        OP_EMPTY,
        OP_POP_RD,
        OP_POP_LAT,
        OP_RD_HEAD,
        OP_RD_TAIL,
        OP_RD_CUR,
        OP_WALK_INIT,
        OP_WALK_CHK,
        OP_FRONT1,
        OP_FRONT2,
        OP_BACK1,
        OP_BACK2,
        OP_AFTER1,
        OP_AFTER2,
        OP_BEFORE1,
        OP_BEFORE2,
        OP_TAKE_FRONT,
        OP_TAKE_BACK,
        OP_UNLINK,
        OP_FPOS_ONE,
        OP_FPOS_CNT,
        OP_REV_W,
        OP_SWAP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             match;
        logic             walk_end;
        logic             rev_more;
        logic             out_free;
    } sts_t;

    function automatic logic is_node(input logic [LNK_W-1:0] l);
        return l < LNK_W'(POOL_NODES);
    endfunction

endpackage

/* sv/dlle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/dlle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlle_ctrl
// Command sequencer: decodes a transaction and steps the datapath through
// reads, key compares, list walks and link updates.
// ----------------------------------------------------------------------------
module dlle_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dlle_pkg::sts_t sts,
    output dlle_pkg::ctl_t ctl
);
    import dlle_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_POP_LAT  = 15'b000000000000100,
        S_HEAD_RD  = 15'b000000000001000,
        S_TAIL_RD  = 15'b000000000010000,
        S_HEAD_CHK = 15'b000000000100000,
        S_TAIL_CHK = 15'b000000001000000,
        S_WALK_RD  = 15'b000000010000000,
        S_WALK_CHK = 15'b000000100000000,
        S_LINK1    = 15'b000001000000000,
        S_LINK2    = 15'b000010000000000,
        S_UNLINK   = 15'b000100000000000,
        S_REV_RD   = 15'b001000000000000,
        S_REV_W    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } state_t;

    typedef enum logic [1:0] {
        K_FRONT,
        K_BACK,
        K_AFTER,
        K_BEFORE
    } kind_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ctl.load   = in_valid && (state_reg == S_IDLE);
        ctl.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.cmd <= CMD_INS_BEFORE)
                begin
                    if (sts.full)
                    begin
                        ctl.op     = OP_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.op     = OP_POP_RD;
                        state_next = S_POP_LAT;
                    end
                end
                else if (sts.cmd <= CMD_SEARCH && sts.empty)
                begin
                    ctl.op     = OP_EMPTY;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_DEL_BACK)
                begin
                    ctl.op     = OP_RD_TAIL;
                    state_next = S_TAIL_CHK;
                end
                else if (sts.cmd <= CMD_SEARCH)
                begin
                    ctl.op     = OP_RD_HEAD;
                    state_next = S_HEAD_CHK;
                end
                else if (sts.cmd == CMD_REVERSE)
                begin
                    ctl.op     = OP_WALK_INIT;
                    state_next = S_REV_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_LAT:
            begin
                ctl.op = OP_POP_LAT;
                if (sts.empty || sts.cmd == CMD_INS_FRONT)
                begin
                    kind_next  = K_FRONT;
                    state_next = S_LINK1;
                end
                else if (sts.cmd == CMD_INS_BACK)
                begin
                    kind_next  = K_BACK;
                    state_next = S_LINK1;
                end
                else if (sts.cmd == CMD_INS_AFTER)
                begin
                    state_next = S_TAIL_RD;
                end
                else
                begin
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                ctl.op     = OP_RD_HEAD;
                state_next = S_HEAD_CHK;
            end
            S_TAIL_RD:
            begin
                ctl.op     = OP_RD_TAIL;
                state_next = S_TAIL_CHK;
            end
            S_HEAD_CHK:
            begin
                if (sts.cmd == CMD_DEL_FRONT || (sts.cmd == CMD_DEL_KEY && sts.match))
                begin
                    ctl.op     = OP_TAKE_FRONT;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_SEARCH && sts.match)
                begin
                    ctl.op     = OP_FPOS_ONE;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_INS_BEFORE && sts.match)
                begin
                    kind_next  = K_FRONT;
                    state_next = S_LINK1;
                end
                else if (sts.cmd == CMD_INS_BEFORE)
                begin
                    ctl.op     = OP_WALK_INIT;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    ctl.op     = OP_RD_TAIL;
                    state_next = S_TAIL_CHK;
                end
            end
            S_TAIL_CHK:
            begin
                if (sts.cmd == CMD_DEL_BACK || (sts.cmd == CMD_DEL_KEY && sts.match))
                begin
                    ctl.op     = OP_TAKE_BACK;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_SEARCH && sts.match)
                begin
                    ctl.op     = OP_FPOS_CNT;
                    state_next = S_DONE;
                end
                else if (sts.cmd == CMD_INS_AFTER && sts.match)
                begin
                    kind_next  = K_BACK;
                    state_next = S_LINK1;
                end
                else
                begin
                    ctl.op     = OP_WALK_INIT;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                ctl.op     = OP_RD_CUR;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                ctl.op = OP_WALK_CHK;
                if (sts.match)
                begin
                    if (sts.cmd == CMD_INS_AFTER)
                    begin
                        kind_next  = K_AFTER;
                        state_next = S_LINK1;
                    end
                    else if (sts.cmd == CMD_INS_BEFORE)
                    begin
                        kind_next  = K_BEFORE;
                        state_next = S_LINK1;
                    end
                    else if (sts.cmd == CMD_DEL_KEY)
                    begin
                        state_next = S_UNLINK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (sts.walk_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_LINK1:
            begin
                unique case (kind_reg)
                    K_FRONT:  ctl.op = OP_FRONT1;
                    K_BACK:   ctl.op = OP_BACK1;
                    K_AFTER:  ctl.op = OP_AFTER1;
                    K_BEFORE: ctl.op = OP_BEFORE1;
                    default:  ctl.op = OP_NONE;
                endcase
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                unique case (kind_reg)
                    K_FRONT:  ctl.op = OP_FRONT2;
                    K_BACK:   ctl.op = OP_BACK2;
                    K_AFTER:  ctl.op = OP_AFTER2;
                    K_BEFORE: ctl.op = OP_BEFORE2;
                    default:  ctl.op = OP_NONE;
                endcase
                state_next = S_DONE;
            end
            S_UNLINK:
            begin
                ctl.op     = OP_UNLINK;
                state_next = S_DONE;
            end
            S_REV_RD:
            begin
                if (sts.rev_more)
                begin
                    ctl.op     = OP_RD_CUR;
                    state_next = S_REV_W;
                end
                else
                begin
                    ctl.op     = OP_SWAP;
                    state_next = S_DONE;
                end
            end
            S_REV_W:
            begin
                ctl.op     = OP_REV_W;
                state_next = S_REV_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_FRONT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

/* sv/dlle_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlle_datapath
// Node memories, free-node stack, list pointers, walk registers and the
// result register of the doubly linked list engine.
// ----------------------------------------------------------------------------
module dlle_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dlle_pkg::ctl_t                   ctl,
    output dlle_pkg::sts_t                   sts,
    input  logic [dlle_pkg::CMD_W-1:0]       command,
    input  logic signed [dlle_pkg::VAL_W-1:0] new_value,
    input  logic signed [dlle_pkg::VAL_W-1:0] key_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dlle_pkg::ST_W-1:0]        status,
    output logic [dlle_pkg::OUT_W-1:0]       found_position,
    output logic [dlle_pkg::OUT_W-1:0]       list_length
);
    import dlle_pkg::*;

    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [LNK_W-1:0] head_reg, head_next;
    logic [LNK_W-1:0] tail_reg, tail_next;
    logic [LNK_W-1:0] cnt_reg, cnt_next;
    logic [LNK_W-1:0] fcnt_reg, fcnt_next;
    logic [LNK_W-1:0] lw_reg, lw_next;
    logic [LNK_W-1:0] cur_reg, cur_next;
    logic [LNK_W-1:0] pos_reg, pos_next;
    logic [LNK_W-1:0] nxt_reg, nxt_next;
    logic [LNK_W-1:0] prv_reg, prv_next;
    logic [IDX_W-1:0] newn_reg, newn_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [LNK_W-1:0] fpos_reg, fpos_next;
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  ost_reg, ost_next;
    logic [LNK_W-1:0] ofpos_reg, ofpos_next;
    logic [LNK_W-1:0] olen_reg, olen_next;

    logic             val_we;
    logic [IDX_W-1:0] val_waddr;
    logic [VAL_W-1:0] val_wdata;
    logic [VAL_W-1:0] val_rdata;
    logic             nx_we;
    logic [IDX_W-1:0] nx_waddr;
    logic [LNK_W-1:0] nx_wdata;
    logic [LNK_W-1:0] nx_rdata;
    logic             pv_we;
    logic [IDX_W-1:0] pv_waddr;
    logic [LNK_W-1:0] pv_wdata;
    logic [LNK_W-1:0] pv_rdata;
    logic             fs_we;
    logic [IDX_W-1:0] fs_waddr;
    logic [IDX_W-1:0] fs_wdata;
    logic [IDX_W-1:0] fs_raddr;
    logic [IDX_W-1:0] fs_rdata;
    logic [IDX_W-1:0] rd_addr;

    logic [LNK_W-1:0] pop_pos;
    logic [LNK_W-1:0] newn_lnk;
    logic             match;

    assign pop_pos  = fcnt_reg - LNK_W'(1);
    assign newn_lnk = LNK_W'(newn_reg);
    assign fs_raddr = pop_pos[IDX_W-1:0];
    assign match    = (val_rdata == key_reg);

    assign sts.cmd      = cmd_reg;
    assign sts.empty    = !is_node(head_reg) || !is_node(tail_reg);
    assign sts.full     = (fcnt_reg == '0);
    assign sts.match    = match;
    assign sts.walk_end = !is_node(nx_rdata) || (pos_reg == LNK_W'(POOL_NODES));
    assign sts.rev_more = is_node(cur_reg) && (pos_reg <= LNK_W'(POOL_NODES));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = ost_reg;
    assign found_position = OUT_W'(ofpos_reg);
    assign list_length    = OUT_W'(olen_reg);

    always_comb
    begin
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        fcnt_next      = fcnt_reg;
        lw_next        = lw_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        newn_next      = newn_reg;
        st_next        = st_reg;
        fpos_next      = fpos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ost_next       = ost_reg;
        ofpos_next     = ofpos_reg;
        olen_next      = olen_reg;
        val_we         = 1'b0;
        val_waddr      = newn_reg;
        val_wdata      = val_reg;
        nx_we          = 1'b0;
        nx_waddr       = newn_reg;
        nx_wdata       = NIL;
        pv_we          = 1'b0;
        pv_waddr       = newn_reg;
        pv_wdata       = NIL;
        fs_we          = 1'b0;
        fs_waddr       = fcnt_reg[IDX_W-1:0];
        fs_wdata       = head_reg[IDX_W-1:0];
        rd_addr        = cur_reg[IDX_W-1:0];

        if (ctl.load)
        begin
            cmd_next  = command;
            val_next  = new_value;
            key_next  = key_value;
            st_next   = ST_OK;
            fpos_next = '0;
        end

        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_FULL:
            begin
                st_next = ST_FULL;
            end
            OP_EMPTY:
            begin
                st_next = ST_EMPTY;
            end
            OP_POP_RD:
            begin
            end
            OP_POP_LAT:
            begin
                if (pop_pos < lw_reg)
                begin
                    newn_next = IDX_W'(POOL_NODES - 1) - pop_pos[IDX_W-1:0];
                end
                else
                begin
                    newn_next = fs_rdata;
                end
            end
            OP_RD_HEAD:
            begin
                rd_addr = head_reg[IDX_W-1:0];
            end
            OP_RD_TAIL:
            begin
                rd_addr = tail_reg[IDX_W-1:0];
            end
            OP_RD_CUR:
            begin
                rd_addr = cur_reg[IDX_W-1:0];
            end
            OP_WALK_INIT:
            begin
                cur_next = head_reg;
                pos_next = LNK_W'(1);
            end
            OP_WALK_CHK:
            begin
                nxt_next = nx_rdata;
                prv_next = pv_rdata;
                if (match)
                begin
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        fpos_next = pos_reg;
                    end
                end
                else
                begin
                    cur_next = nx_rdata;
                    pos_next = pos_reg + LNK_W'(1);
                    if (!is_node(nx_rdata) || pos_reg == LNK_W'(POOL_NODES))
                    begin
                        st_next = ST_NOTFOUND;
                    end
                end
            end
            OP_FRONT1:
            begin
                val_we   = 1'b1;
                nx_we    = 1'b1;
                nx_wdata = head_reg;
                pv_we    = is_node(head_reg);
                pv_waddr = head_reg[IDX_W-1:0];
                pv_wdata = newn_lnk;
            end
            OP_FRONT2:
            begin
                pv_we     = 1'b1;
                head_next = newn_lnk;
                if (!is_node(head_reg))
                begin
                    tail_next = newn_lnk;
                end
            end
            OP_BACK1:
            begin
                val_we   = 1'b1;
                pv_we    = 1'b1;
                pv_wdata = tail_reg;
                nx_we    = is_node(tail_reg);
                nx_waddr = tail_reg[IDX_W-1:0];
                nx_wdata = newn_lnk;
            end
            OP_BACK2:
            begin
                nx_we     = 1'b1;
                tail_next = newn_lnk;
                if (!is_node(tail_reg))
                begin
                    head_next = newn_lnk;
                end
            end
            OP_AFTER1:
            begin
                val_we   = 1'b1;
                pv_we    = 1'b1;
                pv_wdata = cur_reg;
                nx_we    = 1'b1;
                nx_wdata = nxt_reg;
                if (!is_node(nxt_reg))
                begin
                    tail_next = newn_lnk;
                end
            end
            OP_AFTER2:
            begin
                pv_we    = is_node(nxt_reg);
                pv_waddr = nxt_reg[IDX_W-1:0];
                pv_wdata = newn_lnk;
                nx_we    = 1'b1;
                nx_waddr = cur_reg[IDX_W-1:0];
                nx_wdata = newn_lnk;
            end
            OP_BEFORE1:
            begin
                val_we   = 1'b1;
                nx_we    = 1'b1;
                nx_wdata = cur_reg;
                pv_we    = 1'b1;
                pv_wdata = prv_reg;
                if (!is_node(prv_reg))
                begin
                    head_next = newn_lnk;
                end
            end
            OP_BEFORE2:
            begin
                nx_we    = is_node(prv_reg);
                nx_waddr = prv_reg[IDX_W-1:0];
                nx_wdata = newn_lnk;
                pv_we    = 1'b1;
                pv_waddr = cur_reg[IDX_W-1:0];
                pv_wdata = newn_lnk;
            end
            OP_TAKE_FRONT:
            begin
                if (head_reg == tail_reg)
                begin
                    head_next = NIL;
                    tail_next = NIL;
                end
                else
                begin
                    head_next = nx_rdata;
                    pv_we     = is_node(nx_rdata);
                    pv_waddr  = nx_rdata[IDX_W-1:0];
                    pv_wdata  = NIL;
                end
                fs_wdata = head_reg[IDX_W-1:0];
            end
            OP_TAKE_BACK:
            begin
                if (tail_reg == head_reg)
                begin
                    head_next = NIL;
                    tail_next = NIL;
                end
                else
                begin
                    tail_next = pv_rdata;
                    nx_we     = is_node(pv_rdata);
                    nx_waddr  = pv_rdata[IDX_W-1:0];
                    nx_wdata  = NIL;
                end
                fs_wdata = tail_reg[IDX_W-1:0];
            end
            OP_UNLINK:
            begin
                if (is_node(prv_reg))
                begin
                    nx_we    = 1'b1;
                    nx_waddr = prv_reg[IDX_W-1:0];
                    nx_wdata = nxt_reg;
                end
                else
                begin
                    head_next = nxt_reg;
                end
                if (is_node(nxt_reg))
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nxt_reg[IDX_W-1:0];
                    pv_wdata = prv_reg;
                end
                else
                begin
                    tail_next = prv_reg;
                end
                fs_wdata = cur_reg[IDX_W-1:0];
            end
            OP_FPOS_ONE:
            begin
                fpos_next = LNK_W'(1);
            end
            OP_FPOS_CNT:
            begin
                fpos_next = cnt_reg;
            end
            OP_REV_W:
            begin
                nx_we    = 1'b1;
                nx_waddr = cur_reg[IDX_W-1:0];
                nx_wdata = pv_rdata;
                pv_we    = 1'b1;
                pv_waddr = cur_reg[IDX_W-1:0];
                pv_wdata = nx_rdata;
                cur_next = nx_rdata;
                pos_next = pos_reg + LNK_W'(1);
            end
            OP_SWAP:
            begin
                head_next = tail_reg;
                tail_next = head_reg;
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                ost_next       = st_reg;
                ofpos_next     = fpos_reg;
                olen_next      = cnt_reg;
            end
            default:
            begin
            end
        endcase

        // commit the popped node
        if (ctl.op == OP_FRONT2 || ctl.op == OP_BACK2 ||
            ctl.op == OP_AFTER2 || ctl.op == OP_BEFORE2)
        begin
            fcnt_next = pop_pos;
            cnt_next  = cnt_reg + LNK_W'(1);
            if (pop_pos < lw_reg)
            begin
                lw_next = pop_pos;
            end
        end

        // return the removed node to the free stack
        if (ctl.op == OP_TAKE_FRONT || ctl.op == OP_TAKE_BACK || ctl.op == OP_UNLINK)
        begin
            if (fcnt_reg < LNK_W'(POOL_NODES))
            begin
                fs_we     = 1'b1;
                fcnt_next = fcnt_reg + LNK_W'(1);
            end
            cnt_next = cnt_reg - LNK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cnt_reg       <= '0;
            fcnt_reg      <= LNK_W'(POOL_NODES);
            lw_reg        <= LNK_W'(POOL_NODES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            fcnt_reg      <= fcnt_next;
            lw_reg        <= lw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        key_reg   <= key_next;
        cur_reg   <= cur_next;
        pos_reg   <= pos_next;
        nxt_reg   <= nxt_next;
        prv_reg   <= prv_next;
        newn_reg  <= newn_next;
        st_reg    <= st_next;
        fpos_reg  <= fpos_next;
        ost_reg   <= ost_next;
        ofpos_reg <= ofpos_next;
        olen_reg  <= olen_next;
    end

    dlle_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    dlle_ram #(.WIDTH(LNK_W), .DEPTH(POOL_NODES)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (rd_addr),
        .rdata (nx_rdata)
    );

    dlle_ram #(.WIDTH(LNK_W), .DEPTH(POOL_NODES)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (rd_addr),
        .rdata (pv_rdata)
    );

    dlle_ram #(.WIDTH(IDX_W), .DEPTH(POOL_NODES)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

endmodule

/* sv/doubly_linked_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Statuses full/empty and undefined commands go from decode to done; end
// deletes read the head or tail; inserts pop a free node and link it; key
// commands check the ends, then walk node by node; reverse rewrites each
// node, then swaps the ends. One transaction at a time; in_ready rises with
// out_valid. Reset: empty list, all nodes free; no memory clearing is needed.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dlle_pkg::CMD_W-1:0]        command,
    input  logic signed [dlle_pkg::VAL_W-1:0] new_value,
    input  logic signed [dlle_pkg::VAL_W-1:0] key_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dlle_pkg::ST_W-1:0]         status,
    output logic [dlle_pkg::OUT_W-1:0]        found_position,
    output logic [dlle_pkg::OUT_W-1:0]        list_length
);
    import dlle_pkg::*;

    ctl_t ctl;
    sts_t sts;

    dlle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    dlle_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .command        (command),
        .new_value      (new_value),
        .key_value      (key_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .list_length    (list_length)
    );

endmodule
